// ----- hw/rtl/bank_switch_mapper_scanline_irq_defines.svh -----
// assertion macros for the bank switch mapper
`ifndef BANK_SWITCH_MAPPER_SCANLINE_IRQ_DEFINES_SVH
`define BANK_SWITCH_MAPPER_SCANLINE_IRQ_DEFINES_SVH

`ifndef SYNTHESIS
`define BSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSM_ASSERT_NOW(lbl, ante, cons, msg)
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/bsm_pkg.sv -----
// types and constants shared by the bank switch mapper files
package bsm_pkg;

    localparam int WORK_RAM_BYTES_DEF = 8192;
    localparam int MAX_PRG_BANKS      = 64;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;

    localparam logic [8:0] LINE_LIMIT        = 9'd240;
    localparam logic [8:0] DOT_SPRITE_TABLE  = 9'd260;
    localparam logic [8:0] DOT_BG_TABLE      = 9'd324;
    localparam logic [6:0] TALL_SPRITE_LIMIT = 7'd8;
    localparam logic [6:0] PRG_COUNT_MIN     = 7'd2;
    localparam logic [6:0] PRG_COUNT_RESET   = 7'd64;
    localparam logic [8:0] NO_LINE           = 9'h1FF;

    // bank select codes
    localparam logic [2:0] SEL_CHR_2K_LAST = 3'd1;
    localparam logic [2:0] SEL_CHR_1K_FIRST = 3'd2;
    localparam logic [2:0] SEL_CHR_1K_LAST = 3'd5;

    typedef enum logic [1:0] {
        ACT_CPU_WRITE    = 2'd0,
        ACT_CPU_READ     = 2'd1,
        ACT_PATTERN_READ = 2'd2,
        ACT_SCANLINE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_RAM     = 2'd1,
        TGT_PRG_ROM = 2'd2,
        TGT_PATTERN = 2'd3
    } t_target;

    // cpu register windows at 0x8000, 0xA000, 0xC000, 0xE000
    typedef enum logic [1:0] {
        WIN_BANK       = 2'd0,
        WIN_MIRROR     = 2'd1,
        WIN_IRQ_LATCH  = 2'd2,
        WIN_IRQ_ENABLE = 2'd3
    } t_window;

    typedef enum logic {
        REG_PRG_BANK_COUNT = 1'b0
    } t_reg_index;

    typedef struct packed {
        t_action     action;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  ppu_control;
        logic [6:0]  sprites_on_line;
        logic [8:0]  scanline;
        logic [8:0]  dot;
    } t_in_item;

    typedef struct packed {
        logic        claimed;
        t_target     target;
        logic [18:0] rom_address;
        logic [7:0]  read_data;
        logic        mirror_horizontal;
        logic        irq_request;
    } t_out_item;

endpackage

// ----- hw/rtl/bsm_stream_if.sv -----
// valid/ready channel carrying one payload beat
interface bsm_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/bsm_ram.sv -----
// single port ram with registered read
module bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/bank_switch_mapper_scanline_irq.sv -----
// bank switch mapper with scanline irq counter, top level
//
//  port     dir  handshake            beat
//  i_in     in   valid/ready          one action (write, read, pattern read, scanline)
//  o_out    out  valid/ready          one result per action
//  apb      in   psel/penable/pwrite  bank count register, pready tied high
//
// one action per clock sustained unless the output stalls; the work ram has one port
// and is read or written in the cycle the beat is taken; a result passes the holding
// stage and the output register, which also absorb stalls; input ready drops
// only when both are full and the output beat is not taken
// reset is synchronous and clears the mapper registers; work ram is not cleared
module bank_switch_mapper_scanline_irq #(
    parameter int WORK_RAM_BYTES = bsm_pkg::WORK_RAM_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bsm_stream_if.sink                      i_in,
    bsm_stream_if.source                    o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bsm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bsm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bsm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    `include "bank_switch_mapper_scanline_irq_defines.svh"

    localparam int AW = $clog2(WORK_RAM_BYTES);

    // mapper registers
    logic [2:0] r_bank_index, n_bank_index;
    logic       r_prg_swap, n_prg_swap;
    logic       r_chr_inv, n_chr_inv;
    logic [7:0] r_chr_bank [6];
    logic [7:0] n_chr_bank [6];
    logic [5:0] r_prg_bank [2];
    logic [5:0] n_prg_bank [2];
    logic       r_mirror, n_mirror;
    logic       r_ram_protect, n_ram_protect;
    logic [7:0] r_irq_reload, n_irq_reload;
    logic [7:0] r_irq_count, n_irq_count;
    logic       r_reload_pending, n_reload_pending;
    logic       r_irq_enabled, n_irq_enabled;
    logic [8:0] r_last_line, n_last_line;
    logic [6:0] r_prg_bank_count, n_prg_bank_count;

    // pipeline
    logic                r_s1_valid;
    bsm_pkg::t_out_item  r_s1_item;
    logic                r_s1_ram_rd;
    bsm_pkg::t_out_item  s1_beat;
    logic                r_out_valid;
    bsm_pkg::t_out_item  r_out_item;

    logic               accept;
    logic               s1_move;
    logic               cfg_wr;
    bsm_pkg::t_in_item  in_item;
    bsm_pkg::t_out_item res;
    bsm_pkg::t_window   window;
    logic               is_ram_window;
    logic               counter_clock;
    logic               line_ok;
    logic               filter_ok;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_addr;
    logic [7:0]         ram_rdata;
    logic [12:0]        chr_v;
    logic [2:0]         chr_sel;
    logic [7:0]         chr_byte;
    logic [18:0]        chr_rom;
    logic [6:0]         prg_n;
    logic [5:0]         prg_last;
    logic [5:0]         prg_second;
    logic [5:0]         prg_sel;
    logic [18:0]        prg_rom;

    // ram index modulo the ram size; the quotient stays below 8
    function automatic logic [AW-1:0] ram_slot(input logic [12:0] a);
        logic [13:0] r;
        int          k;
        begin
            r = {1'b0, a};
            for (k = 2; k >= 0; k--) begin
                if (int'(r) >= (WORK_RAM_BYTES << k)) begin
                    r = r - 14'(WORK_RAM_BYTES << k);
                end
            end
            return r[AW-1:0];
        end
    endfunction

    assign in_item  = i_in.payload;
    assign s1_move  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign accept   = i_in.valid && i_in.ready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (bsm_pkg::t_reg_index'(paddr[2]) == bsm_pkg::REG_PRG_BANK_COUNT)
                    ? {{(bsm_pkg::APB_DATA_W - 7){1'b0}}, r_prg_bank_count}
                    : '0;

    assign window        = bsm_pkg::t_window'(in_item.address[14:13]);
    assign is_ram_window = in_item.address[15:13] == 3'b011;

    // pattern translation
    assign chr_v    = in_item.address[12:0] ^ {r_chr_inv, 12'b0};
    assign chr_sel  = chr_v[12] ? ({1'b0, chr_v[11:10]} + bsm_pkg::SEL_CHR_1K_FIRST)
                                : {2'b00, chr_v[11]};
    assign chr_byte = r_chr_bank[chr_sel];
    assign chr_rom  = chr_v[12] ? {1'b0, chr_byte, in_item.address[9:0]}
                                : {1'b0, chr_byte[7:1], in_item.address[10:0]};

    // program translation, fixed banks from the clamped bank count
    always_comb begin
        prg_n = r_prg_bank_count;
        if (prg_n < bsm_pkg::PRG_COUNT_MIN) begin
            prg_n = bsm_pkg::PRG_COUNT_MIN;
        end
        if (prg_n > 7'(bsm_pkg::MAX_PRG_BANKS)) begin
            prg_n = 7'(bsm_pkg::MAX_PRG_BANKS);
        end
    end

    assign prg_last   = 6'(prg_n - 7'd1);
    assign prg_second = 6'(prg_n - 7'd2);

    always_comb begin
        case (window)
            bsm_pkg::WIN_BANK:      prg_sel = r_prg_swap ? prg_second : r_prg_bank[0];
            bsm_pkg::WIN_MIRROR:    prg_sel = r_prg_bank[1];
            bsm_pkg::WIN_IRQ_LATCH: prg_sel = r_prg_swap ? r_prg_bank[0] : prg_second;
            default:                prg_sel = prg_last;
        endcase
    end

    assign prg_rom = {prg_sel, in_item.address[12:0]};

    // scanline filter
    assign line_ok = (in_item.scanline < bsm_pkg::LINE_LIMIT) &&
                     (in_item.scanline != r_last_line);

    always_comb begin
        if (in_item.ppu_control[5]) begin
            filter_ok = in_item.sprites_on_line < bsm_pkg::TALL_SPRITE_LIMIT;
        end else if (!in_item.ppu_control[4] && in_item.ppu_control[3]) begin
            filter_ok = in_item.dot == bsm_pkg::DOT_SPRITE_TABLE;
        end else if (in_item.ppu_control[4] && !in_item.ppu_control[3]) begin
            filter_ok = in_item.dot == bsm_pkg::DOT_BG_TABLE;
        end else begin
            filter_ok = 1'b1;
        end
    end

    assign counter_clock = accept && (in_item.action == bsm_pkg::ACT_SCANLINE) &&
                           line_ok && filter_ok;

    assign ram_addr = ram_slot(in_item.address[12:0]);
    assign ram_we   = accept && (in_item.action == bsm_pkg::ACT_CPU_WRITE) &&
                      is_ram_window && !r_ram_protect;
    assign ram_re   = accept && (in_item.action == bsm_pkg::ACT_CPU_READ) && is_ram_window;

    bsm_ram #(
        .WIDTH (8),
        .DEPTH (WORK_RAM_BYTES)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (in_item.data),
        .o_rdata (ram_rdata)
    );

    // register updates and the result of the beat being taken
    always_comb begin
        n_bank_index     = r_bank_index;
        n_prg_swap       = r_prg_swap;
        n_chr_inv        = r_chr_inv;
        n_chr_bank       = r_chr_bank;
        n_prg_bank       = r_prg_bank;
        n_mirror         = r_mirror;
        n_ram_protect    = r_ram_protect;
        n_irq_reload     = r_irq_reload;
        n_irq_count      = r_irq_count;
        n_reload_pending = r_reload_pending;
        n_irq_enabled    = r_irq_enabled;
        n_last_line      = r_last_line;
        n_prg_bank_count = r_prg_bank_count;

        res = '0;

        if (cfg_wr &&
            bsm_pkg::t_reg_index'(paddr[2]) == bsm_pkg::REG_PRG_BANK_COUNT) begin
            n_prg_bank_count = pwdata[6:0];
        end

        if (accept) begin
            case (in_item.action)
                bsm_pkg::ACT_CPU_WRITE: begin
                    if (in_item.address[15:13] >= 3'b011) begin
                        res.claimed = 1'b1;
                        if (is_ram_window) begin
                            res.target      = bsm_pkg::TGT_RAM;
                            res.rom_address = 19'(ram_addr);
                        end else begin
                            case (window)
                                bsm_pkg::WIN_BANK: begin
                                    if (!in_item.address[0]) begin
                                        n_bank_index = in_item.data[2:0];
                                        n_prg_swap   = in_item.data[6];
                                        n_chr_inv    = in_item.data[7];
                                    end else begin
                                        case (r_bank_index) inside
                                            [3'd0:bsm_pkg::SEL_CHR_2K_LAST]: begin
                                                n_chr_bank[r_bank_index] =
                                                    {in_item.data[7:1], 1'b0};
                                            end
                                            [bsm_pkg::SEL_CHR_1K_FIRST:
                                             bsm_pkg::SEL_CHR_1K_LAST]: begin
                                                n_chr_bank[r_bank_index] = in_item.data;
                                            end
                                            default: begin
                                                n_prg_bank[r_bank_index[0]] =
                                                    in_item.data[5:0];
                                            end
                                        endcase
                                    end
                                end
                                bsm_pkg::WIN_MIRROR: begin
                                    if (!in_item.address[0]) begin
                                        n_mirror = in_item.data[0];
                                    end else begin
                                        n_ram_protect = in_item.data[6];
                                    end
                                end
                                bsm_pkg::WIN_IRQ_LATCH: begin
                                    if (!in_item.address[0]) begin
                                        n_irq_reload = in_item.data;
                                    end else begin
                                        n_irq_count      = 8'd0;
                                        n_reload_pending = 1'b1;
                                    end
                                end
                                default: begin
                                    n_irq_enabled = in_item.address[0];
                                end
                            endcase
                        end
                    end
                end
                bsm_pkg::ACT_CPU_READ: begin
                    if (in_item.address[15:13] >= 3'b011) begin
                        res.claimed = 1'b1;
                        if (is_ram_window) begin
                            res.target      = bsm_pkg::TGT_RAM;
                            res.rom_address = 19'(ram_addr);
                        end else begin
                            res.target      = bsm_pkg::TGT_PRG_ROM;
                            res.rom_address = prg_rom;
                        end
                    end
                end
                bsm_pkg::ACT_PATTERN_READ: begin
                    if (in_item.address[15:13] == 3'b000) begin
                        res.claimed     = 1'b1;
                        res.target      = bsm_pkg::TGT_PATTERN;
                        res.rom_address = chr_rom;
                    end
                end
                default: begin
                    if (counter_clock) begin
                        res.claimed = 1'b1;
                        if (r_reload_pending || r_irq_count == 8'd0) begin
                            n_irq_count      = r_irq_reload;
                            n_reload_pending = 1'b0;
                        end else begin
                            n_irq_count = r_irq_count - 8'd1;
                        end
                        n_last_line     = in_item.scanline;
                        res.irq_request = (n_irq_count == 8'd0) && r_irq_enabled;
                    end
                end
            endcase
        end

        res.mirror_horizontal = n_mirror;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_index     <= '0;
            r_prg_swap       <= 1'b0;
            r_chr_inv        <= 1'b0;
            r_chr_bank       <= '{default: '0};
            r_prg_bank       <= '{default: '0};
            r_mirror         <= 1'b0;
            r_ram_protect    <= 1'b0;
            r_irq_reload     <= '0;
            r_irq_count      <= '0;
            r_reload_pending <= 1'b0;
            r_irq_enabled    <= 1'b0;
            r_last_line      <= bsm_pkg::NO_LINE;
            r_prg_bank_count <= bsm_pkg::PRG_COUNT_RESET;
            r_s1_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_bank_index     <= n_bank_index;
            r_prg_swap       <= n_prg_swap;
            r_chr_inv        <= n_chr_inv;
            r_chr_bank       <= n_chr_bank;
            r_prg_bank       <= n_prg_bank;
            r_mirror         <= n_mirror;
            r_ram_protect    <= n_ram_protect;
            r_irq_reload     <= n_irq_reload;
            r_irq_count      <= n_irq_count;
            r_reload_pending <= n_reload_pending;
            r_irq_enabled    <= n_irq_enabled;
            r_last_line      <= n_last_line;
            r_prg_bank_count <= n_prg_bank_count;

            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ram data joins the beat as it leaves the holding stage
    always_comb begin
        s1_beat           = r_s1_item;
        s1_beat.read_data = r_s1_ram_rd ? ram_rdata : 8'd0;
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item   <= res;
            r_s1_ram_rd <= ram_re;
        end
        if (s1_move) begin
            r_out_item <= s1_beat;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    `BSM_ASSERT_NOW(a_stall_blocks_input, r_s1_valid && r_out_valid && !o_out.ready, !i_in.ready, "input taken while both stages are full")
    `BSM_ASSERT_NEXT(a_clock_clears_reload, counter_clock, !r_reload_pending, "reload flag still set after a counter clock")
    `BSM_ASSERT_NOW(a_irq_claimed, o_out.valid && o_out.payload.irq_request, o_out.payload.claimed && o_out.payload.target == bsm_pkg::TGT_NONE, "irq on a beat that did not clock the counter")
    `BSM_ASSERT_NOW(a_ram_data_only_ram, o_out.valid && o_out.payload.target != bsm_pkg::TGT_RAM, o_out.payload.read_data == 8'd0, "read data on a beat that did not hit work ram")
endmodule
